@@ sv/egcd_pkg.sv @@
// Shared types for the extended gcd / modular inverse block.
// State encoding and the command/status bundles between controller and datapath.
// No dependencies.
package egcd_pkg;

  localparam int COEF_BITS = 32;
  localparam int GCD_BITS  = 31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_REMCHK,
    ST_MULA,
    ST_MULB,
    ST_UPDB,
    ST_FINISH
  } egcd_state_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic euclid_step;
    logic mul_go;
    logic mul_beta;
    logic upd_alpha;
    logic upd_beta;
    logic out_load;
  } egcd_cmd_t;

  typedef struct packed {
    logic rb_zero;
    logic div_last;
    logic rem_zero;
  } egcd_status_t;

endpackage

@@ sv/egcd_dp.sv @@
// Datapath: remainder pair, bit-serial restoring divider, shared coefficient
// multiplier and the output word register. Driven by egcd_ctrl; uses egcd_pkg.
module egcd_dp import egcd_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [VALUE_BITS-1:0]       modulus,
  input  logic [VALUE_BITS-1:0]       value,
  input  egcd_cmd_t                   cmd,
  output egcd_status_t                status,
  output logic [GCD_BITS-1:0]         gcd,
  output logic signed [COEF_BITS-1:0] coef_alpha,
  output logic signed [COEF_BITS-1:0] coef_beta,
  output logic                        inverse_exists,
  output logic                        zero_divisor
);

  localparam int CW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] ra;
  logic [VALUE_BITS-1:0] rb;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] quo;
  logic [CW-1:0]         cnt;
  logic [COEF_BITS-1:0]  al_prev;
  logic [COEF_BITS-1:0]  al_cur;
  logic [COEF_BITS-1:0]  be_prev;
  logic [COEF_BITS-1:0]  be_cur;
  logic [COEF_BITS-1:0]  prod;
  logic                  zd;

  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic [COEF_BITS-1:0]  q_low;
  logic [COEF_BITS-1:0]  mul_opnd;

  // one restoring step: shift next dividend bit in, try subtracting rb
  assign trial    = {rem, quo[VALUE_BITS-1]};
  assign diff     = trial - {1'b0, rb};
  // coefficients wrap mod 2^32, so only the low quotient bits matter
  assign q_low    = COEF_BITS'(quo);
  assign mul_opnd = cmd.mul_beta ? be_cur : al_cur;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ra      <= modulus;
      rb      <= value;
      al_prev <= COEF_BITS'(1);
      al_cur  <= '0;
      be_prev <= '0;
      be_cur  <= COEF_BITS'(1);
      zd      <= (value == '0);
    end
    if (cmd.div_init) begin
      rem <= '0;
      quo <= ra;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      quo <= {quo[VALUE_BITS-2:0], ~diff[VALUE_BITS]};
      rem <= diff[VALUE_BITS] ? trial[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
    end
    if (cmd.euclid_step) begin
      ra <= rb;
      rb <= rem;
    end
    if (cmd.mul_go) begin
      prod <= q_low * mul_opnd;
    end
    if (cmd.upd_alpha) begin
      al_prev <= al_cur;
      al_cur  <= al_prev - prod;
    end
    if (cmd.upd_beta) begin
      be_prev <= be_cur;
      be_cur  <= be_prev - prod;
    end
    if (cmd.out_load) begin
      gcd            <= zd ? '0 : GCD_BITS'(ra);
      coef_alpha     <= zd ? '0 : al_cur;
      coef_beta      <= zd ? '0 : be_cur;
      inverse_exists <= !zd && (ra == VALUE_BITS'(1));
      zero_divisor   <= zd;
    end
  end

  assign status.rb_zero  = (rb == '0);
  assign status.div_last = (cnt == CW'(VALUE_BITS - 1));
  assign status.rem_zero = (rem == '0);

  // Euclid step always leaves the new remainder below the new divisor
  a_step_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.euclid_step |=> (rb < ra))
    else $error("remainder not below divisor after Euclid step");

  a_div_init: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |=> (rem == '0) && (cnt == '0))
    else $error("divider not cleared at start");

  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && zd |=> (gcd == '0) && !inverse_exists && zero_divisor)
    else $error("zero divisor word carries nonzero fields");

endmodule

@@ sv/egcd_ctrl.sv @@
// Controller: sequences load, bit-serial divide, Euclid step and the two
// coefficient updates, and owns the output valid. Uses egcd_pkg.
module egcd_ctrl import egcd_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  egcd_status_t status,
  output egcd_cmd_t    cmd
);

  egcd_state_t state;
  egcd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (status.rb_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_REMCHK;
        end
      end
      ST_REMCHK: begin
        cmd.euclid_step = 1'b1;
        state_next      = status.rem_zero ? ST_FINISH : ST_MULA;
      end
      ST_MULA: begin
        cmd.mul_go = 1'b1;
        state_next = ST_MULB;
      end
      ST_MULB: begin
        cmd.upd_alpha = 1'b1;
        cmd.mul_go    = 1'b1;
        cmd.mul_beta  = 1'b1;
        state_next    = ST_UPDB;
      end
      ST_UPDB: begin
        cmd.upd_beta = 1'b1;
        cmd.div_init = 1'b1;
        state_next   = ST_DIVIDE;
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> (state == ST_START))
    else $error("accepted word did not start processing");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output word overwritten while stalled");

  a_done_on_zero_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REMCHK) && status.rem_zero |=> (state == ST_FINISH))
    else $error("zero remainder did not end the run");

endmodule

@@ sv/extended_gcd_mod_inverse.sv @@
// Extended Euclid / modular inverse, one word at a time.
// Each quotient step runs the bit-serial divider (one quotient bit per cycle), then
// the remainder check and, unless the remainder is zero, the two coefficient multiplies
// and updates. A zero value skips the divider. Next word is accepted the cycle after
// the result reaches the output register; a stalled output word holds the result back.
// Synchronous active-high reset returns to idle.
module extended_gcd_mod_inverse import egcd_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [VALUE_BITS-1:0]       modulus,
  input  logic [VALUE_BITS-1:0]       value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [GCD_BITS-1:0]         gcd,
  output logic signed [COEF_BITS-1:0] coef_alpha,
  output logic signed [COEF_BITS-1:0] coef_beta,
  output logic                        inverse_exists,
  output logic                        zero_divisor
);

  egcd_cmd_t    cmd;
  egcd_status_t status;

  egcd_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  egcd_dp #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .modulus        (modulus),
    .value          (value),
    .cmd            (cmd),
    .status         (status),
    .gcd            (gcd),
    .coef_alpha     (coef_alpha),
    .coef_beta      (coef_beta),
    .inverse_exists (inverse_exists),
    .zero_divisor   (zero_divisor)
  );

endmodule

@@ verif/extended_gcd_mod_inverse_test.sv @@
// Self-checking bench for extended_gcd_mod_inverse: gcd plus signed Bezout coefficients.
// Runs a directed table, then random operand pairs under random valid/stall gaps.
// Depends on egcd_pkg and the extended_gcd_mod_inverse RTL.
module extended_gcd_mod_inverse_test import egcd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPND_BITS    = 31;
  localparam int RANDOM_WORDS = 366;
  localparam int HOLD_CYCLES  = 4000;
  localparam int DRAIN_CYCLES = 2000;
  localparam logic [OPND_BITS-1:0] VMAX = '1;

  typedef struct packed {
    logic [GCD_BITS-1:0]  gcd;
    logic [COEF_BITS-1:0] alpha;
    logic [COEF_BITS-1:0] beta;
    logic                 inv;
    logic                 zdiv;
  } bezout_t;

  typedef struct packed {
    logic [OPND_BITS-1:0] m;
    logic [OPND_BITS-1:0] v;
    logic                 typed;
    bezout_t              want;
  } stim_row_t;

  localparam bezout_t NONE     = '0;
  localparam bezout_t ZERO_DIV = {31'd0, 32'd0, 32'd0, 1'b0, 1'b1};

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [OPND_BITS-1:0]        modulus = '0;
  logic [OPND_BITS-1:0]        value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [GCD_BITS-1:0]         gcd;
  logic signed [COEF_BITS-1:0] coef_alpha;
  logic signed [COEF_BITS-1:0] coef_beta;
  logic                        inverse_exists;
  logic                        zero_divisor;

  bezout_t         pending_bezout[$];
  int              bad_fields = 0;
  int              snd_idle_pct = 27;
  int              rcv_idle_pct = 52;
  logic            hold_output = 1'b0;
  longint unsigned fib [0:46];

  // Extremes and special cases; typed rows carry their answer, the rest use the predictor.
  stim_row_t directed_rows [0:24] = '{
    {31'd0,     31'd0,     1'b1, ZERO_DIV},
    {VMAX,      31'd0,     1'b1, ZERO_DIV},
    {31'd12345, 31'd0,     1'b1, ZERO_DIV},
    {31'd0,     31'd5,     1'b1, {31'd5, 32'd0, 32'd1, 1'b0, 1'b0}},
    {31'd0,     31'd1,     1'b1, {31'd1, 32'd0, 32'd1, 1'b1, 1'b0}},
    {31'd0,     VMAX,      1'b1, {VMAX,  32'd0, 32'd1, 1'b0, 1'b0}},
    {31'd7,     31'd7,     1'b1, {31'd7, 32'd0, 32'd1, 1'b0, 1'b0}},
    {VMAX,      VMAX,      1'b1, {VMAX,  32'd0, 32'd1, 1'b0, 1'b0}},
    {VMAX,      31'd1,     1'b1, {31'd1, 32'd0, 32'd1, 1'b1, 1'b0}},
    {31'd1,     VMAX,      1'b1, {31'd1, 32'd1, 32'd0, 1'b1, 1'b0}},
    {31'd1,     31'd1,     1'b1, {31'd1, 32'd0, 32'd1, 1'b1, 1'b0}},
    {31'd10,    31'd4,     1'b0, NONE},
    {31'd4,     31'd10,    1'b0, NONE},
    {31'd240,   31'd46,    1'b0, NONE},
    {31'd1836311903, 31'd1134903170, 1'b0, NONE},
    {31'd1134903170, 31'd1836311903, 1'b0, NONE},
    {VMAX,      31'd2,     1'b0, NONE},
    {VMAX,      31'h7FFFFFFE, 1'b0, NONE},
    {31'h7FFFFFFE, 31'h7FFFFFFD, 1'b0, NONE},
    {31'h40000000, 31'd3,  1'b0, NONE},
    {31'h55555555, 31'h2AAAAAAA, 1'b0, NONE},
    {31'h2AAAAAAA, 31'h55555555, 1'b0, NONE},
    {31'd1000000007, 31'd123456789, 1'b0, NONE},
    {31'h7FFFFFFE, VMAX,   1'b0, NONE},
    {31'h40000000, 31'h20000000, 1'b0, NONE}
  };

  extended_gcd_mod_inverse #(.VALUE_BITS(OPND_BITS)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .modulus        (modulus),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .gcd            (gcd),
    .coef_alpha     (coef_alpha),
    .coef_beta      (coef_beta),
    .inverse_exists (inverse_exists),
    .zero_divisor   (zero_divisor)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Euclid with coefficients kept as wrapping 64-bit two's complement.
  function automatic bezout_t bezout_of(input logic [OPND_BITS-1:0] m,
                                        input logic [OPND_BITS-1:0] v);
    bezout_t    res;
    logic [63:0] ra, rb, q, r, a_prev, b_prev, a_cur, b_cur, a_next, b_next;
    logic        done;
    res = '0;
    if (v == '0) begin
      res.zdiv = 1'b1;
      return res;
    end
    ra = 64'(m);
    rb = 64'(v);
    a_prev = 64'd1;
    b_prev = 64'd0;
    a_cur = 64'd0;
    b_cur = 64'd1;
    done = 1'b0;
    while (!done) begin
      q = ra / rb;
      r = ra % rb;
      ra = rb;
      rb = r;
      if (r == 64'd0) begin
        done = 1'b1;
      end else begin
        a_next = a_prev - q * a_cur;
        b_next = b_prev - q * b_cur;
        a_prev = a_cur;
        b_prev = b_cur;
        a_cur = a_next;
        b_cur = b_next;
      end
    end
    res.gcd   = ra[GCD_BITS-1:0];
    res.alpha = a_cur[COEF_BITS-1:0];
    res.beta  = b_cur[COEF_BITS-1:0];
    res.inv   = (ra == 64'd1);
    return res;
  endfunction

  task automatic pick_operands(output logic [OPND_BITS-1:0] m, output logic [OPND_BITS-1:0] v);
    int unsigned          k, g;
    logic [OPND_BITS-1:0] t;
    case ($urandom_range(0, 9))
      2: begin
        m = OPND_BITS'($urandom_range(0, 255));
        v = OPND_BITS'($urandom_range(0, 255));
      end
      3: begin
        // consecutive Fibonacci numbers give the longest quotient chains
        k = $urandom_range(2, 46);
        m = OPND_BITS'(fib[k]);
        v = OPND_BITS'(fib[k-1]);
        if ($urandom_range(0, 1)) begin
          t = m;
          m = v;
          v = t;
        end
      end
      4: begin
        g = $urandom_range(2, 1000);
        m = OPND_BITS'(g * $urandom_range(1, 100000));
        v = OPND_BITS'(g * $urandom_range(1, 100000));
      end
      5: begin
        m = VMAX;
        v = OPND_BITS'($urandom);
      end
      6: begin
        k = $urandom_range(1, 31);
        m = OPND_BITS'($urandom & ((32'h1 << k) - 1));
        k = $urandom_range(1, 31);
        v = OPND_BITS'($urandom & ((32'h1 << k) - 1));
      end
      7: begin
        m = OPND_BITS'($urandom);
        v = OPND_BITS'($urandom);
        case ($urandom_range(0, 3))
          0: v = '0;
          1: m = '0;
          2: v = m;
          default: v = OPND_BITS'($urandom_range(1, 3));
        endcase
      end
      8: begin
        m = OPND_BITS'($urandom);
        v = OPND_BITS'($urandom);
        if (m > v) begin
          t = m;
          m = v;
          v = t;
        end
      end
      default: begin
        m = OPND_BITS'($urandom);
        v = OPND_BITS'($urandom);
      end
    endcase
  endtask

  task automatic offer_word(input logic [OPND_BITS-1:0] m, input logic [OPND_BITS-1:0] v,
                            input logic typed, input bezout_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    modulus  <= m;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_bezout.push_back(typed ? want : bezout_of(m, v));
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      bad_fields = bad_fields + 1;
      $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // Receiver: random stall, plus one long hold-off so the block backs up its input.
  initial begin : output_side
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    bezout_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_bezout.size() == 0) begin
        bad_fields = bad_fields + 1;
        $display("%0t: unexpected word, expected none, got gcd %0h", $realtime, gcd);
      end else begin
        want = pending_bezout.pop_front();
        compare_field("gcd", 64'(want.gcd), 64'(gcd));
        compare_field("coef_alpha", 64'(want.alpha), 64'($unsigned(coef_alpha)));
        compare_field("coef_beta", 64'(want.beta), 64'($unsigned(coef_beta)));
        compare_field("inverse_exists", 64'(want.inv), 64'(inverse_exists));
        compare_field("zero_divisor", 64'(want.zdiv), 64'(zero_divisor));
      end
    end
  end

  initial begin : stimulus
    logic [OPND_BITS-1:0] m, v;
    fib[0] = 0;
    fib[1] = 1;
    for (int i = 2; i <= 46; i++) fib[i] = fib[i-1] + fib[i-2];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_word(directed_rows[i].m, directed_rows[i].v, directed_rows[i].typed,
                 directed_rows[i].want);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) begin
        snd_idle_pct = 52;
        rcv_idle_pct = 27;
      end
      if (n == 2 * RANDOM_WORDS / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_output = 1'b1;
      end
      pick_operands(m, v);
      offer_word(m, v, 1'b0, NONE);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_bezout.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_fields == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ extended_gcd_mod_inverse.f @@
sv/egcd_pkg.sv
sv/egcd_dp.sv
sv/egcd_ctrl.sv
sv/extended_gcd_mod_inverse.sv
verif/extended_gcd_mod_inverse_test.sv
